// ===== rtl/vth_pkg.sv =====
// Package for the vector-to-heading/height pipeline: widths, CORDIC angle table,
// angle constants. No dependencies.
package vth_pkg;
	localparam int CORDIC_STEPS = 22;
	localparam int CORDIC_FRAC = 16;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int NORM_TOP = 38;
	localparam int DW = 44;
	localparam int ZW = 24;
	localparam logic [20:0] GAIN_Q20 = 21'd1726753;

	typedef logic signed [DW-1:0] cval_t;
	typedef logic signed [ZW-1:0] ang_t;

	typedef struct packed {
		logic valid_res;
		logic zero_z;
		logic zero_x;
		logic zero_y;
		logic flip;
		logic sec;
		logic y_pos;
	} flags_t;

	function automatic ang_t atan_entry(input int i);
		ang_t r;
		case (i)
			0: r = 24'sd2949120;
			1: r = 24'sd1740967;
			2: r = 24'sd919879;
			3: r = 24'sd466945;
			4: r = 24'sd234379;
			5: r = 24'sd117304;
			6: r = 24'sd58666;
			7: r = 24'sd29335;
			8: r = 24'sd14668;
			9: r = 24'sd7334;
			10: r = 24'sd3667;
			11: r = 24'sd1833;
			12: r = 24'sd917;
			13: r = 24'sd458;
			14: r = 24'sd229;
			15: r = 24'sd115;
			16: r = 24'sd57;
			17: r = 24'sd29;
			18: r = 24'sd14;
			19: r = 24'sd7;
			20: r = 24'sd4;
			21: r = 24'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

// ===== rtl/vth_cordic_stage.sv =====
// One registered CORDIC vectoring iteration with stall, valid and side data.
// Depends on vth_pkg.
module vth_cordic_stage
	import vth_pkg::*;
#(
	parameter int STEP = 0,
	parameter int SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  cval_t in_x,
	input  cval_t in_y,
	input  ang_t in_z,
	input  logic [SW-1:0] in_side,
	output logic out_v,
	output cval_t out_x,
	output cval_t out_y,
	output ang_t out_z,
	output logic [SW-1:0] out_side
);
	cval_t dx, dy;
	assign dx = in_x >>> STEP;
	assign dy = in_y >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= in_side;
			if (!in_y[DW-1]) begin
				out_x <= in_x + dy;
				out_y <= in_y - dx;
				out_z <= in_z + atan_entry(STEP);
			end else begin
				out_x <= in_x - dy;
				out_y <= in_y + dx;
				out_z <= in_z - atan_entry(STEP);
			end
		end
	end
endmodule

// ===== rtl/vector_to_heading_height.sv =====
// Top level: direction vector to heading and height angles, deep pipeline.
// Depends on vth_pkg and vth_cordic_stage.
//
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | dir_x, dir_y, dir_z
// m_axis  | out | heading[14:0], height[30:15], valid_res[31]
//
// One transfer per cycle while the output is not stalled; the depth is set by
// two chained 22-step CORDIC pipelines (heading CORDIC runs beside the first).
// Reset clears the valid bits only. A stalled output freezes the whole pipe.
module vector_to_heading_height
	import vth_pkg::*;
#(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata, // dir_x, dir_y, dir_z
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata // heading, height, valid_res
);
	localparam int CW = COMPONENT_WIDTH;
	localparam int NS = CORDIC_STEPS;
	localparam int SH = CORDIC_FRAC - ANGLE_FRAC_BITS;
	localparam logic [15:0] RIGHT = 16'(90 << ANGLE_FRAC_BITS);
	localparam logic [15:0] HALF = 16'(180 << ANGLE_FRAC_BITS);
	localparam logic [15:0] FULL = 16'(360 << ANGLE_FRAC_BITS);
	localparam ang_t TOPA = ang_t'(90 << CORDIC_FRAC);
	localparam int SW = $bits(flags_t) + CW;

	logic en;
	logic out_v_q;
	assign en = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: signs, magnitudes, max
	logic signed [CW-1:0] ix, iy, iz;
	assign ix = s_axis_tdata[CW-1:0];
	assign iy = s_axis_tdata[2*CW-1:CW];
	assign iz = s_axis_tdata[3*CW-1:2*CW];
	logic [CW-1:0] mx, my, mz;
	assign mx = ix[CW-1] ? CW'(-ix) : CW'(ix);
	assign my = iy[CW-1] ? CW'(-iy) : CW'(iy);
	assign mz = iz[CW-1] ? CW'(-iz) : CW'(iz);

	logic v_s1;
	logic [CW-1:0] mx_s1, my_s1, mz_s1, mh_s1, ma_s1;
	flags_t f_s1;
	flags_t fin;
	always_comb begin
		logic xp, zp, xn;
		xp = ix != '0 && !ix[CW-1];
		xn = ix[CW-1];
		zp = iz != '0 && !iz[CW-1];
		fin.zero_x = ix == '0;
		fin.zero_y = iy == '0;
		fin.zero_z = iz == '0;
		fin.valid_res = !(fin.zero_x && fin.zero_y && fin.zero_z);
		fin.flip = xn != iz[CW-1];
		fin.sec = (zp && !xn) || (!zp && xp);
		fin.y_pos = iy != '0 && !iy[CW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= mx; my_s1 <= my; mz_s1 <= mz; f_s1 <= fin;
			mh_s1 <= (mx > mz) ? mx : mz;
			ma_s1 <= (mx > mz) ? ((mx > my) ? mx : my) : ((mz > my) ? mz : my);
		end
	end

	// stage 2: normalize shifts (priority encode)
	function automatic logic [5:0] lead(input logic [CW-1:0] m);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < CW; i++) if (m[i]) p = 6'(i);
		return 6'(NORM_TOP) - p;
	endfunction

	logic v_s2;
	cval_t hx_s2, hy_s2, ax_s2, ay_s2;
	logic [CW-1:0] my_s2;
	logic [5:0] as_s2;
	flags_t f_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			hx_s2 <= cval_t'(DW'(mz_s1) << lead(mh_s1));
			hy_s2 <= cval_t'(DW'(mx_s1) << lead(mh_s1));
			ax_s2 <= cval_t'(DW'(mz_s1) << lead(ma_s1));
			ay_s2 <= cval_t'(DW'(mx_s1) << lead(ma_s1));
			as_s2 <= lead(ma_s1);
			my_s2 <= my_s1;
			f_s2 <= f_s1;
		end
	end

	// two parallel CORDIC chains; chain A carries side data
	cval_t hx [NS+1], hy [NS+1], ax [NS+1], ay [NS+1];
	ang_t hz [NS+1], az [NS+1];
	logic hv [NS+1], av [NS+1];
	logic [0:0] hs [NS+1];
	logic [SW-1:0] asd [NS+1];
	logic [5:0] ash [NS+1];
	assign hx[0] = hx_s2; assign hy[0] = hy_s2; assign hz[0] = '0; assign hv[0] = v_s2;
	assign ax[0] = ax_s2; assign ay[0] = ay_s2; assign az[0] = '0; assign av[0] = v_s2;
	assign hs[0] = '0;
	assign asd[0] = {f_s2, my_s2};
	assign ash[0] = as_s2;

	for (genvar g = 0; g < NS; g++) begin : g_c1
		vth_cordic_stage #(.STEP(g), .SW(1)) u_h (
			.clk, .arst_n, .en, .in_v(hv[g]), .in_x(hx[g]), .in_y(hy[g]), .in_z(hz[g]),
			.in_side(hs[g]), .out_v(hv[g+1]), .out_x(hx[g+1]), .out_y(hy[g+1]),
			.out_z(hz[g+1]), .out_side(hs[g+1]));
		vth_cordic_stage #(.STEP(g), .SW(SW)) u_a (
			.clk, .arst_n, .en, .in_v(av[g]), .in_x(ax[g]), .in_y(ay[g]), .in_z(az[g]),
			.in_side(asd[g]), .out_v(av[g+1]), .out_x(ax[g+1]), .out_y(ay[g+1]),
			.out_z(az[g+1]), .out_side(asd[g+1]));
		always_ff @(posedge clk) if (en) ash[g+1] <= ash[g];
	end

	// stage M: gain multiply of |y|, round heading
	logic v_m;
	cval_t rx_m, gy_m;
	flags_t f_m;
	logic [15:0] hd_m;
	function automatic logic [15:0] to_units(input ang_t z);
		ang_t c;
		c = z[ZW-1] ? '0 : (z > TOPA ? TOPA : z);
		return 16'((c + ang_t'(1 << (SH-1))) >>> SH);
	endfunction
	flags_t fa;
	logic [CW-1:0] mya;
	assign {fa, mya} = asd[NS];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m <= 1'b0;
		else if (en) v_m <= av[NS];
	end
	logic [CW+20:0] gprod;
	logic [DW+20:0] prod;
	assign gprod = (CW+21)'(mya) * (CW+21)'(GAIN_Q20);
	assign prod = (DW+21)'(gprod) << ash[NS];
	always_ff @(posedge clk) begin
		if (en) begin
			rx_m <= ax[NS];
			gy_m <= cval_t'(prod >> 20);
			f_m <= fa;
			hd_m <= to_units(hz[NS]);
		end
	end
	// heading chain aligns with chain A: both NS stages from stage 2

	cval_t bx [NS+1], by [NS+1];
	ang_t bz [NS+1];
	logic bv [NS+1];
	logic [SW-1:0] bs [NS+1];
	logic [15:0] bh [NS+1];
	assign bx[0] = rx_m; assign by[0] = gy_m; assign bz[0] = '0; assign bv[0] = v_m;
	assign bs[0] = {f_m, CW'(0)};
	assign bh[0] = hd_m;
	for (genvar g = 0; g < NS; g++) begin : g_c2
		vth_cordic_stage #(.STEP(g), .SW(SW)) u_b (
			.clk, .arst_n, .en, .in_v(bv[g]), .in_x(bx[g]), .in_y(by[g]), .in_z(bz[g]),
			.in_side(bs[g]), .out_v(bv[g+1]), .out_x(bx[g+1]), .out_y(by[g+1]),
			.out_z(bz[g+1]), .out_side(bs[g+1]));
		always_ff @(posedge clk) if (en) bh[g+1] <= bh[g];
	end

	// stage R: round asin, apply quadrants
	flags_t fb;
	assign fb = bs[NS][SW-1:CW];
	logic [15:0] a_r, hd_r;
	flags_t f_r;
	logic v_r;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_r <= 1'b0;
		else if (en) v_r <= bv[NS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			a_r <= to_units(bz[NS]);
			hd_r <= bh[NS];
			f_r <= fb;
		end
	end

	logic [15:0] head_c, hgt_c;
	always_comb begin
		head_c = '0;
		hgt_c = '0;
		if (f_r.valid_res) begin
			if (f_r.zero_x && f_r.zero_z) begin
				hgt_c = f_r.y_pos ? RIGHT : 16'(3 * RIGHT);
			end else begin
				if (f_r.zero_z) head_c = RIGHT;
				else if (f_r.zero_x) head_c = '0;
				else begin
					head_c = f_r.flip ? HALF - hd_r : hd_r;
					if (head_c >= HALF) head_c = HALF - 16'd1;
				end
				if (f_r.zero_y) hgt_c = f_r.sec ? '0 : HALF;
				else begin
					if (f_r.sec) hgt_c = f_r.y_pos ? a_r : FULL - a_r;
					else hgt_c = f_r.y_pos ? HALF - a_r : HALF + a_r;
					if (hgt_c >= FULL) hgt_c = FULL - 16'd1;
				end
			end
		end
	end

	logic [31:0] out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= v_r;
	end
	always_ff @(posedge clk) begin
		if (en) out_q <= {f_r.valid_res, hgt_c, head_c[14:0]};
	end
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_q;

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !m_axis_tready |=> out_v_q && $stable(out_q))
		else $error("result changed under stall");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_q[31] |-> out_q[30:0] == '0)
		else $error("zero vector with nonzero angles");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> out_q[14:0] < HALF[14:0] && out_q[30:15] < FULL)
		else $error("angle out of range");
`endif
endmodule

// ===== tb/vth_checker.sv =====
// Checker for vector_to_heading_height: watches both stream channels, predicts
// heading/height with its own CORDIC model and compares. Does not import vth_pkg.
`timescale 1ns / 100ps
module vth_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [47:0] in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] out_data,
	output int          errors,
	output int          pending,
	output int          seen
);
	typedef struct packed {
		logic        valid_res;
		logic [15:0] height;
		logic [14:0] heading;
	} angles_t;

	localparam longint ATAN_TBL [22] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2};

	angles_t angle_q[$];

	function automatic longint floor_shift(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint rotate_vec(inout longint cx, inout longint cy);
		longint acc, dx, dy;
		acc = 0;
		for (int i = 0; i < 22; i++) begin
			dx = floor_shift(cy, i);
			dy = floor_shift(cx, i);
			if (cy >= 0) begin
				cx += dx; cy -= dy; acc += ATAN_TBL[i];
			end else begin
				cx -= dx; cy += dy; acc -= ATAN_TBL[i];
			end
		end
		return acc;
	endfunction

	function automatic int lead_shift(longint m);
		int s;
		s = 0;
		while (s < 63 && (m << s) < (64'sd1 <<< 38)) s++;
		return s;
	endfunction

	function automatic longint angle_units(longint a);
		if (a < 0) a = 0;
		if (a > (64'sd90 <<< 16)) a = 64'sd90 <<< 16;
		return (a + (64'sd1 <<< 8)) >>> 9;
	endfunction

	function automatic angles_t predict_angles(logic [47:0] d);
		logic signed [15:0] vx, vy, vz;
		longint xm, ym, zm, m, cx, cy, cy2, t, a, hd, ht;
		int s;
		bit sec;
		angles_t r;
		vx = d[15:0]; vy = d[31:16]; vz = d[47:32];
		xm = vx < 0 ? -longint'(vx) : vx;
		ym = vy < 0 ? -longint'(vy) : vy;
		zm = vz < 0 ? -longint'(vz) : vz;
		r = '0;
		hd = 0; ht = 0;
		if (vx == 0 && vy == 0 && vz == 0) return r;
		if (vx == 0 && vz == 0) begin
			ht = vy > 0 ? 90*128 : 270*128;
		end else begin
			if (vz == 0) hd = 90*128;
			else if (vx != 0) begin
				m = xm > zm ? xm : zm;
				s = lead_shift(m);
				cx = zm << s; cy = xm << s;
				t = angle_units(rotate_vec(cx, cy));
				hd = ((vx < 0) != (vz < 0)) ? 180*128 - t : t;
				if (hd >= 180*128) hd = 180*128 - 1;
			end
			sec = (vz > 0 && vx >= 0) || (vz <= 0 && vx > 0);
			if (vy == 0) ht = sec ? 0 : 180*128;
			else begin
				m = xm > zm ? xm : zm;
				if (ym > m) m = ym;
				s = lead_shift(m);
				cx = zm << s; cy = xm << s;
				void'(rotate_vec(cx, cy));
				cy2 = ((ym << s) * 1726753) >>> 20;
				a = angle_units(rotate_vec(cx, cy2));
				if (sec) ht = vy > 0 ? a : 360*128 - a;
				else ht = vy > 0 ? 180*128 - a : 180*128 + a;
				if (ht >= 360*128) ht = 360*128 - 1;
			end
		end
		r.heading = hd[14:0];
		r.height = ht[15:0];
		r.valid_res = 1'b1;
		return r;
	endfunction

	initial begin
		errors = 0;
		seen = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		angles_t want, got;
		if (arst_n) begin
			if (in_valid && in_ready) angle_q.push_back(predict_angles(in_data));
			if (out_valid && out_ready) begin
				got = out_data;
				seen++;
				if (angle_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected transfer %h", out_data);
				end else begin
					want = angle_q.pop_front();
					if (want !== got) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: heading %0d/%0d height %0d/%0d valid %0b/%0b",
								want.heading, got.heading, want.height, got.height,
								want.valid_res, got.valid_res);
					end
				end
			end
		end
		pending = angle_q.size();
	end
endmodule

// ===== tb/tb_vector_to_heading_height.sv =====
// Testbench top for vector_to_heading_height: drives directed and random vectors
// with random gaps and stalls; checking lives in vth_checker.
`timescale 1ns / 100ps
module tb_vector_to_heading_height;
	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata; // dir_x, dir_y, dir_z
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata; // heading, height, valid_res
	int          errors, pending, seen, cycles;
	bit          sent_all;
	logic [47:0] vec_list[$];

	vector_to_heading_height dut (.*);
	vth_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
		.errors(errors), .pending(pending), .seen(seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'h7FFF;
			3: return 16'($signed($urandom_range(0, 8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [15:0] ex[7];
		ex = '{0, 1, -1, 32767, -32768, 100, -100};
		for (int i = 0; i < 7; i++) begin
			vec_list.push_back({ex[i], 16'sd0, 16'sd0});
			vec_list.push_back({16'sd0, ex[i], 16'sd0});
			vec_list.push_back({16'sd0, 16'sd0, ex[i]});
		end
		vec_list.push_back({16'h8000, 16'h8000, 16'h8000});
		vec_list.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
		vec_list.push_back({16'h7FFF, 16'h8000, 16'h0001});
		for (int i = 0; i < 400; i++)
			vec_list.push_back({rand_comp(), rand_comp(), rand_comp()});
	end

	initial begin
		int gap;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		sent_all = 0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1;
		foreach (vec_list[i]) begin
			gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 0;
				repeat (gap) @(negedge clk);
			end
			s_axis_tvalid <= 1;
			s_axis_tdata <= vec_list[i];
			do @(posedge clk); while (!s_axis_tready);
			@(negedge clk);
		end
		s_axis_tvalid <= 0;
		sent_all = 1;
	end

	initial begin
		int gap;
		m_axis_tready = 0;
		@(posedge arst_n);
		@(negedge clk);
		m_axis_tready <= 1;
		repeat (40) @(negedge clk);
		m_axis_tready <= 0;
		repeat (200) @(negedge clk);
		forever begin
			gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 15) : 0;
			if (gap > 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 200000) begin
				$display("timeout after %0d cycles", cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		wait (sent_all);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		$display("covered %0d vectors (axis, extreme and random), %0d results checked",
			vec_list.size(), seen);
		if (errors == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
